// ===== rtl/ffr_pkg.sv =====
`default_nettype none
package ffr_pkg;

  // Store geometry
  localparam int BLOCK_BYTES = 4096;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = ADDR_W + 1;

  // Frame bytes
  localparam logic [7:0] HDR_BYTE  = 8'h0A;
  localparam logic [7:0] TRL_FIRST = 8'h00;
  localparam logic [7:0] TRL_LAST  = 8'h0B;
  localparam logic [7:0] ORDER_LIMIT    = 8'd7;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd6;

  typedef enum logic [1:0] {
    ACT_APPEND   = 2'd0,
    ACT_FIND     = 2'd1,
    ACT_LEFTOVER = 2'd2,
    ACT_NEW      = 2'd3
  } ffr_action_t;

  typedef struct packed {
    ffr_action_t action;
    logic [7:0]  data_byte;
  } ffr_in_t;

  typedef struct packed {
    logic              found;
    logic [2:0]        frame_order;
    logic [ADDR_W-1:0] region_start;
    logic [CNT_W-1:0]  region_length;
  } ffr_out_t;

  // Byte store access: one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ffr_ram_req_t;

endpackage
`default_nettype wire

// ===== rtl/ffr_in_if.sv =====
`default_nettype none
interface ffr_in_if import ffr_pkg::*; ();
  logic    valid;
  logic    ready;
  ffr_in_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffr_out_if.sv =====
`default_nettype none
interface ffr_out_if import ffr_pkg::*; ();
  logic     valid;
  logic     ready;
  ffr_out_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// ===== rtl/frame_finder_with_resync.sv =====
`default_nettype none
// Append and start-new-block transfers are taken back to back, one per cycle, while idle.
// Leftover query: res is loaded at the transfer, then moved to the output register in S_EMIT;
// the next transfer is taken after that. Find: each candidate header gets an end check that
// also reads its first byte, then up to five more reads (order, two length, two trailer bytes);
// one more check when the scan runs out; S_EMIT loads the output; a held result stalls input.
// Synchronous reset clears counts, scan state and output valid; the byte store is not cleared.
module frame_finder_with_resync import ffr_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  ffr_in_if.sink   req,
  ffr_out_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HDR,
    S_ORD,
    S_LEN0,
    S_LEN1,
    S_TRLA,
    S_TRL0,
    S_TRL1,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] block_count;
  logic [CNT_W-1:0] scan;
  logic [CNT_W-1:0] after_last;
  logic [2:0]       order;
  logic [7:0]       len_lo;
  logic [15:0]      len;
  ffr_out_t         res;

  ffr_ram_req_t ram_req;
  logic [7:0]   rdata;

  logic             take;
  logic [CNT_W-1:0] rem;
  logic [16:0]      len_in;
  logic [16:0]      trl_addr;

  ffr_byte_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign take      = req.valid && req.ready;
  assign rem       = block_count - scan;
  assign len_in    = {1'b0, rdata, len_lo};
  assign trl_addr  = {{(17-CNT_W){1'b0}}, scan} + {1'b0, len} + 17'd4;

  // Store write on append, read address follows the scan step
  always_comb begin
    ram_req.we    = take && (req.item.action == ACT_APPEND) &&
                    (block_count < CNT_W'(BLOCK_BYTES));
    ram_req.waddr = block_count[ADDR_W-1:0];
    ram_req.wdata = req.item.data_byte;
    unique case (state)
      S_HDR:   ram_req.raddr = ADDR_W'(scan + CNT_W'(1));
      S_ORD:   ram_req.raddr = ADDR_W'(scan + CNT_W'(2));
      S_LEN0:  ram_req.raddr = ADDR_W'(scan + CNT_W'(3));
      S_TRLA:  ram_req.raddr = trl_addr[ADDR_W-1:0];
      S_TRL0:  ram_req.raddr = ADDR_W'(trl_addr + 17'd1);
      default: ram_req.raddr = scan[ADDR_W-1:0];
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      scan        <= '0;
      after_last  <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (req.item.action)
              ACT_APPEND: begin
                if (block_count < CNT_W'(BLOCK_BYTES)) begin
                  block_count <= block_count + CNT_W'(1);
                end
              end
              ACT_NEW: begin
                block_count <= '0;
                scan        <= '0;
                after_last  <= '0;
              end
              ACT_FIND: state <= S_CHECK;
              ACT_LEFTOVER: begin
                res.frame_order <= '0;
                if (after_last < block_count) begin
                  res.found         <= 1'b1;
                  res.region_start  <= after_last[ADDR_W-1:0];
                  res.region_length <= block_count - after_last;
                end else begin
                  res.found         <= 1'b0;
                  res.region_start  <= '0;
                  res.region_length <= '0;
                end
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // No room left for any frame: scan runs out to the end
        S_CHECK: begin
          if (scan >= block_count || rem < CNT_W'(FRAME_OVERHEAD + 8'd1)) begin
            scan              <= block_count;
            res.found         <= 1'b0;
            res.frame_order   <= '0;
            res.region_start  <= '0;
            res.region_length <= '0;
            state             <= S_EMIT;
          end else begin
            state <= S_HDR;
          end
        end
        S_HDR: begin
          if (rdata == HDR_BYTE) begin
            state <= S_ORD;
          end else begin
            scan  <= scan + CNT_W'(1);
            state <= S_CHECK;
          end
        end
        S_ORD: begin
          order <= rdata[2:0];
          if (rdata == 8'd0 || rdata >= ORDER_LIMIT) begin
            scan  <= scan + CNT_W'(1);
            state <= S_CHECK;
          end else begin
            state <= S_LEN0;
          end
        end
        S_LEN0: begin
          len_lo <= rdata;
          state  <= S_LEN1;
        end
        // Length must be non-zero and the frame must fit the block
        S_LEN1: begin
          len <= len_in[15:0];
          if (len_in == 17'd0 ||
              len_in + 17'(FRAME_OVERHEAD) > {{(17-CNT_W){1'b0}}, rem}) begin
            scan  <= scan + CNT_W'(1);
            state <= S_CHECK;
          end else begin
            state <= S_TRLA;
          end
        end
        S_TRLA: state <= S_TRL0;
        S_TRL0: begin
          if (rdata == TRL_FIRST) begin
            state <= S_TRL1;
          end else begin
            scan  <= scan + CNT_W'(1);
            state <= S_CHECK;
          end
        end
        S_TRL1: begin
          if (rdata == TRL_LAST) begin
            res.found         <= 1'b1;
            res.frame_order   <= order;
            res.region_start  <= ADDR_W'(scan + CNT_W'(4));
            res.region_length <= CNT_W'(len);
            scan              <= CNT_W'(trl_addr + 17'd1);
            after_last        <= CNT_W'(trl_addr + 17'd2);
            state             <= S_EMIT;
          end else begin
            scan  <= scan + CNT_W'(1);
            state <= S_CHECK;
          end
        end
        // Hand the result over once the output register is free
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.item  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ffr_byte_ram.sv =====
`default_nettype none
module ffr_byte_ram import ffr_pkg::*; (
  input  wire logic         clk,
  input  wire ffr_ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [BLOCK_BYTES];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== tb/sv/ffr_frame_checker.sv =====
// Watches both channels, keeps its own copy of the byte store and scan state,
// and checks every find and leftover answer against its own prediction.
module ffr_frame_checker import ffr_pkg::*; (
  input  logic clk,
  input  logic rst,
  ffr_in_if    req,
  ffr_out_if   rsp,
  output int   fail_count,
  output int   awaiting
);

  logic [7:0]       store_mem [BLOCK_BYTES];
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_pos;
  logic [CNT_W-1:0] tail_start;
  ffr_out_t         reports_due [$];

  // Payload length of a complete frame starting at pos, else 0
  function automatic int payload_len_at(input int pos, output logic [2:0] ord);
    int rem;
    int len;
    ord = '0;
    if (pos >= int'(fill_count)) return 0;
    rem = int'(fill_count) - pos;
    if (rem < int'(FRAME_OVERHEAD) + 1) return 0;
    if (store_mem[pos] != HDR_BYTE) return 0;
    if (store_mem[pos+1] == 8'd0 || store_mem[pos+1] >= ORDER_LIMIT) return 0;
    ord = store_mem[pos+1][2:0];
    len = int'({store_mem[pos+3], store_mem[pos+2]});
    if (len == 0 || len + int'(FRAME_OVERHEAD) > rem) return 0;
    if (store_mem[pos+4+len] != TRL_FIRST || store_mem[pos+5+len] != TRL_LAST) return 0;
    return len;
  endfunction

  // Update the shadow state for one accepted transfer; queue any answer
  task automatic apply_item(input ffr_in_t it);
    ffr_out_t   r;
    int         len;
    logic [2:0] ord;
    bit         hit;
    r   = '0;
    hit = 1'b0;
    case (it.action)
      ACT_APPEND: begin
        // full store: byte dropped
        if (int'(fill_count) < BLOCK_BYTES) begin
          store_mem[int'(fill_count)] = it.data_byte;
          fill_count++;
        end
      end
      ACT_NEW: begin
        fill_count = '0;
        scan_pos   = '0;
        tail_start = '0;
      end
      ACT_FIND: begin
        // resync: step one byte past every failed candidate
        while (!hit && scan_pos < fill_count) begin
          len = payload_len_at(int'(scan_pos), ord);
          if (len != 0) begin
            r.found         = 1'b1;
            r.frame_order   = ord;
            r.region_start  = ADDR_W'(int'(scan_pos) + 4);
            r.region_length = CNT_W'(len);
            scan_pos        = CNT_W'(int'(scan_pos) + len + 5);
            tail_start      = scan_pos + 1'b1;
            hit             = 1'b1;
          end else begin
            scan_pos++;
          end
        end
        reports_due.push_back(r);
      end
      ACT_LEFTOVER: begin
        if (tail_start < fill_count) begin
          r.found         = 1'b1;
          r.region_start  = tail_start[ADDR_W-1:0];
          r.region_length = fill_count - tail_start;
        end
        reports_due.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    ffr_out_t want;
    ffr_out_t got;
    if (rst) begin
      fill_count = '0;
      scan_pos   = '0;
      tail_start = '0;
      reports_due.delete();
    end else begin
      if (req.valid && req.ready) apply_item(req.item);
      if (rsp.valid && rsp.ready) begin
        got = rsp.item;
        if (reports_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer: found=%0d order=%0d start=%0d len=%0d",
                   $time, got.found, got.frame_order, got.region_start, got.region_length);
        end else begin
          want = reports_due.pop_front();
          if (got.found !== want.found || got.frame_order !== want.frame_order ||
              got.region_start !== want.region_start ||
              got.region_length !== want.region_length) begin
            fail_count++;
            $display("%0t: result mismatch: expected found=%0d order=%0d start=%0d len=%0d",
                     $time, want.found, want.frame_order, want.region_start,
                     want.region_length);
            $display("%0t:                  actual   found=%0d order=%0d start=%0d len=%0d",
                     $time, got.found, got.frame_order, got.region_start,
                     got.region_length);
          end
        end
      end
    end
    awaiting = reports_due.size();
  end

endmodule

// ===== tb/sv/frame_finder_with_resync_test.sv =====
module frame_finder_with_resync_test;
  import ffr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffr_in_if  req ();
  ffr_out_if rsp ();

  int fail_count;
  int awaiting;
  int send_idle_pct = 36;
  int recv_idle_pct = 68;
  int holds_asked   = 0;
  int holds_served  = 0;
  int items_sent    = 0;
  int block_fill    = 0;
  int cycle_no      = 0;

  always #5 clk = ~clk;

  frame_finder_with_resync DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ffr_frame_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("[frame_finder_with_resync] ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, plus long hold-offs on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One transfer on the request side; returns at the following falling edge
  task automatic send(input ffr_action_t act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      req.item.action <= ffr_action_t'(2'($urandom));
      req.item.data_byte <= 8'($urandom);
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.item.action <= act;
    req.item.data_byte <= b;
    do @(posedge clk); while (!req.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic append_byte(input logic [7:0] b);
    send(ACT_APPEND, b);
    block_fill++;
  endtask

  task automatic ask(input ffr_action_t act);
    send(act, 8'($urandom));
    if (act == ACT_NEW) block_fill = 0;
  endtask

  // Header, order, length field, body bytes, then a good or damaged trailer
  task automatic append_frame(input logic [7:0] ord, input int len_field, input int body,
                              input bit trailer_ok);
    logic [7:0] t0;
    logic [7:0] t1;
    t0 = TRL_FIRST;
    t1 = TRL_LAST;
    if (!trailer_ok) begin
      if ($urandom_range(1)) begin
        t0 = 8'($urandom_range(1, 255));
      end else begin
        t1 = 8'($urandom);
        if (t1 == TRL_LAST) t1 = ~TRL_LAST;
      end
    end
    append_byte(HDR_BYTE);
    append_byte(ord);
    append_byte(len_field[7:0]);
    append_byte(len_field[15:8]);
    repeat (body) append_byte(8'($urandom));
    append_byte(t0);
    append_byte(t1);
  endtask

  // Change idling; the receiver picks the new rate up at the next falling edge
  task automatic set_phase(input int s_pct, input int r_pct);
    req.valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    @(negedge clk);
  endtask

  // Receiver stops for a long stretch while queries keep coming
  task automatic long_hold();
    req.valid <= 1'b0;
    @(posedge clk);
    holds_asked++;
    @(negedge clk);
    repeat (40) ask($urandom_range(1) ? ACT_FIND : ACT_LEFTOVER);
  endtask

  task automatic directed_cases();
    logic [7:0] seq [$];
    // empty block: no leftover, no frame
    ask(ACT_LEFTOVER);
    ask(ACT_FIND);
    // smallest frame, order 1, payload 0xFF
    seq = {8'h0A, 8'h01, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h0B};
    foreach (seq[i]) append_byte(seq[i]);
    ask(ACT_LEFTOVER);   // whole block before any frame
    ask(ACT_FIND);
    ask(ACT_FIND);       // nothing left
    ask(ACT_LEFTOVER);   // empty leftover
    // frame cut short by the end of the block, then completed by later appends
    seq = {8'h0A, 8'h06, 8'h02, 8'h00};
    foreach (seq[i]) append_byte(seq[i]);
    ask(ACT_FIND);
    seq = {8'h00, 8'h00, 8'h00, 8'h0B};
    foreach (seq[i]) append_byte(seq[i]);
    ask(ACT_FIND);
    ask(ACT_LEFTOVER);
    ask(ACT_NEW);
  endtask

  // Mostly good frames with random content, mixed with noise and broken frames
  task automatic random_traffic(input int count);
    int stop_at;
    int pick;
    int len;
    int n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        append_frame(8'($urandom_range(1, 6)), len, len, 1'b1);
      end else if (pick < 62) begin
        n = $urandom_range(1, 5);
        repeat (n) append_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
      end else if (pick < 70) begin
        // order byte out of range
        len = $urandom_range(1, 8);
        append_frame($urandom_range(1) ? 8'd0 : 8'($urandom_range(7, 255)), len, len, 1'b1);
      end else if (pick < 76) begin
        append_frame(8'($urandom_range(1, 6)), 0, 0, 1'b1);
      end else if (pick < 84) begin
        len = $urandom_range(1, 12);
        append_frame(8'($urandom_range(1, 6)), len, len, 1'b0);
      end else if (pick < 88) begin
        // length runs past the end of the block
        append_frame(8'($urandom_range(1, 6)), $urandom_range(256, 65535),
                     $urandom_range(0, 4), 1'b1);
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        ask(ACT_FIND);
      end else if (pick < 60) begin
        ask(ACT_FIND);
        ask(ACT_FIND);
      end else if (pick < 75) begin
        ask(ACT_LEFTOVER);
      end
      if (block_fill > 160 || $urandom_range(24) == 0) begin
        ask(ACT_NEW);
        if ($urandom_range(3) == 0) ask(ACT_LEFTOVER);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    req.valid = 1'b0;
    req.item  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_cases();
    random_traffic(140);
    long_hold();
    set_phase(68, 36);
    random_traffic(160);
    set_phase(0, 0);
    random_traffic(160);
    random_traffic(30);

    req.valid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[frame_finder_with_resync] OK");
    end else begin
      $display("[frame_finder_with_resync] ERROR");
    end
    $finish;
  end

endmodule
